/* design/nbfr_pkg.sv */
package nbfr_pkg;

   localparam int CELL_COUNT     = 64;
   localparam int LINKS_PER_CELL = 3;
   localparam int COORD_BITS     = 16;

   // request operation codes
   localparam logic OP_LOAD   = 1'b0;
   localparam logic OP_SEARCH = 1'b1;

   // cell index width and queue depth (power of two, at least CELL_COUNT)
   localparam int CIW    = (CELL_COUNT > 2) ? $clog2(CELL_COUNT) : 1;
   localparam int QD     = 2 ** CIW;
   // link slots kept per cell: three come in with a load
   localparam int LSLOTS = (LINKS_PER_CELL < 3) ? LINKS_PER_CELL : 3;
   localparam int LCW    = $clog2(LSLOTS + 1);
   // distance arithmetic
   localparam int MAGW   = COORD_BITS + 1;
   localparam int SUMW   = 2 * COORD_BITS + 2;
   localparam int ROOTW  = COORD_BITS + 1;
   localparam int KW     = ROOTW + 1;

   typedef logic [CIW-1:0] cell_type;
   typedef logic [COORD_BITS-1:0] coord_type;
   typedef logic [2:0][COORD_BITS-1:0] pos_type;

   typedef struct packed {
      logic [LCW-1:0]              count;
      logic [LSLOTS-1:0][CIW-1:0]  link;
   } links_type;

   typedef struct packed {
      cell_type       node;
      logic [KW-1:0]  key;
   } qent_type;

   // low COORD_BITS bits of the field; the sign bit is bit COORD_BITS-1
   function automatic coord_type take_coord(input logic [15:0] raw);
      logic [31:0] w;
      w = 32'(raw);
      return w[COORD_BITS-1:0];
   endfunction

   function automatic logic cell_ok(input logic [5:0] v);
      return ({1'b0, v} < 7'(CELL_COUNT));
   endfunction

endpackage

/* design/navmesh_best_first_route_search.sv */
// Load request: written when taken, next request accepted the cycle after.
// Search request: setup reads start and goal positions; each expanded cell has its links
//   scanned, and each new neighbour is inserted into the queue, shifting larger keys back;
//   the shared distance unit (square/sum, 17 root bits, done) runs twice per queued cell.
// Route: built back from the goal through the parent links, then output while rsp_ready holds.
// Reset (synchronous, active high) clears control state and marks; cell memory is not cleared.
module navmesh_best_first_route_search (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_operation,
   input  logic [5:0]  req_cell_index,
   input  logic [15:0] req_pos_x,
   input  logic [15:0] req_pos_y,
   input  logic [15:0] req_pos_z,
   input  logic [5:0]  req_neighbor_0,
   input  logic [5:0]  req_neighbor_1,
   input  logic [5:0]  req_neighbor_2,
   input  logic [2:0]  req_neighbor_mask,
   input  logic [5:0]  req_start_cell,
   input  logic [5:0]  req_goal_cell,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_found,
   output logic [5:0]  rsp_route_cell,
   output logic        rsp_last
);
   import nbfr_pkg::*;

   typedef enum logic [17:0] {
      S_IDLE   = 18'b000000000000000001,
      S_RDS    = 18'b000000000000000010,
      S_RDG    = 18'b000000000000000100,
      S_EXP    = 18'b000000000000001000,
      S_NB     = 18'b000000000000010000,
      S_DGO1   = 18'b000000000000100000,
      S_DA     = 18'b000000000001000000,
      S_DGO2   = 18'b000000000010000000,
      S_DB     = 18'b000000000100000000,
      S_INSRD  = 18'b000000001000000000,
      S_INSCMP = 18'b000000010000000000,
      S_INSPUT = 18'b000000100000000000,
      S_POP    = 18'b000001000000000000,
      S_BLD0   = 18'b000010000000000000,
      S_BLD    = 18'b000100000000000000,
      S_EMRD   = 18'b001000000000000000,
      S_EMOUT  = 18'b010000000000000000,
      S_FAIL   = 18'b100000000000000000
   } state_type;

   // memories
   pos_type   pos_mem [CELL_COUNT];
   links_type lnk_mem [CELL_COUNT];
   cell_type  par_mem [CELL_COUNT];
   cell_type  stk_mem [CELL_COUNT];
   qent_type  q_mem   [QD];

   pos_type   pos_rd_ff;
   links_type lnk_rd_ff;
   cell_type  par_rd_ff, stk_rd_ff;
   qent_type  q_rd_ff;

   // control and working registers
   state_type             state_ff, state_in;
   cell_type              cur_ff, cur_in, start_ff, start_in, goal_ff, goal_in;
   cell_type              n_ff, n_in, cnt_ff, cnt_in, head_ff, head_in;
   pos_type               spos_ff, spos_in, gpos_ff, gpos_in;
   logic [LCW-1:0]        li_ff, li_in;
   logic [KW-1:0]         key_ff, key_in;
   logic [CIW:0]          qlen_ff, qlen_in, j_ff, j_in;
   logic [CELL_COUNT-1:0] closed_ff, closed_in, open_ff, open_in;
   logic                  rsp_valid_ff, rsp_valid_in, rsp_found_ff, rsp_found_in;
   logic                  rsp_last_ff, rsp_last_in;
   cell_type              rsp_cell_ff, rsp_cell_in;

   // memory ports
   cell_type  pos_raddr, par_raddr, q_raddr;
   logic      par_we, stk_we, q_we;
   cell_type  par_waddr, par_wdata, stk_waddr, stk_wdata, q_waddr;
   qent_type  q_wdata;

   // load compaction
   links_type ld_links;
   logic [2:0][5:0] ld_nb;

   // distance unit
   logic             dist_go, dist_done;
   logic [ROOTW-1:0] dist_val;
   pos_type          dist_a;

   logic req_fire, out_free;
   cell_type nb_cell;

   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign nb_cell   = lnk_rd_ff.link[li_ff];

   always_comb begin
      ld_nb = {req_neighbor_2, req_neighbor_1, req_neighbor_0};
      ld_links = '0;
      for (int i = 0; i < 3; i++) begin
         if (req_neighbor_mask[i] && cell_ok(ld_nb[i]) && (int'(ld_links.count) < LSLOTS)) begin
            ld_links.link[ld_links.count] = ld_nb[i][CIW-1:0];
            ld_links.count = ld_links.count + LCW'(1);
         end
      end
   end

   assign dist_a = (state_ff == S_DGO2 || state_ff == S_DB) ? gpos_ff : spos_ff;

   nbfr_dist u_dist (
      .clock (clock),
      .reset (reset),
      .go    (dist_go),
      .pos_a (dist_a),
      .pos_b (pos_rd_ff),
      .done  (dist_done),
      .span  (dist_val)
   );

   // sequencer
   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      start_in     = start_ff;
      goal_in      = goal_ff;
      n_in         = n_ff;
      cnt_in       = cnt_ff;
      head_in      = head_ff;
      spos_in      = spos_ff;
      gpos_in      = gpos_ff;
      li_in        = li_ff;
      key_in       = key_ff;
      qlen_in      = qlen_ff;
      j_in         = j_ff;
      closed_in    = closed_ff;
      open_in      = open_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_found_in = rsp_found_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_cell_in  = rsp_cell_ff;
      pos_raddr    = n_ff;
      par_raddr    = goal_ff;
      q_raddr      = head_ff;
      par_we       = 1'b0;
      par_waddr    = nb_cell;
      par_wdata    = cur_ff;
      stk_we       = 1'b0;
      stk_waddr    = cnt_ff;
      stk_wdata    = goal_ff;
      q_we         = 1'b0;
      q_waddr      = CIW'(head_ff + j_ff[CIW-1:0]);
      q_wdata      = q_rd_ff;
      dist_go      = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            pos_raddr = req_start_cell[CIW-1:0];
            if (req_fire && req_operation == OP_SEARCH) begin
               if (cell_ok(req_start_cell) && cell_ok(req_goal_cell)) begin
                  start_in  = req_start_cell[CIW-1:0];
                  goal_in   = req_goal_cell[CIW-1:0];
                  closed_in = '0;
                  open_in   = '0;
                  qlen_in   = '0;
                  head_in   = '0;
                  state_in  = S_RDS;
               end else begin
                  state_in = S_FAIL;
               end
            end
         end
         S_RDS: begin
            spos_in   = pos_rd_ff;
            pos_raddr = goal_ff;
            state_in  = S_RDG;
         end
         S_RDG: begin
            gpos_in  = pos_rd_ff;
            cur_in   = start_ff;
            state_in = S_EXP;
         end
         S_EXP: begin
            // link read for cur lands at the end of this cycle
            closed_in[cur_ff] = 1'b1;
            li_in    = '0;
            state_in = S_NB;
         end
         S_NB: begin
            if (li_ff >= lnk_rd_ff.count) begin
               state_in = S_POP;
            end else if (nb_cell == goal_ff) begin
               par_we    = 1'b1;
               stk_we    = 1'b1;
               stk_waddr = '0;
               cnt_in    = CIW'(1);
               state_in  = S_BLD0;
            end else if (open_ff[nb_cell] || closed_ff[nb_cell]) begin
               li_in = li_ff + LCW'(1);
            end else begin
               par_we           = 1'b1;
               open_in[nb_cell] = 1'b1;
               n_in             = nb_cell;
               pos_raddr        = nb_cell;
               state_in         = S_DGO1;
            end
         end
         S_DGO1: begin
            dist_go  = 1'b1;
            state_in = S_DA;
         end
         S_DA: begin
            if (dist_done) begin
               key_in   = KW'(dist_val);
               state_in = S_DGO2;
            end
         end
         S_DGO2: begin
            dist_go  = 1'b1;
            state_in = S_DB;
         end
         S_DB: begin
            if (dist_done) begin
               key_in   = key_ff + KW'(dist_val);
               j_in     = qlen_ff;
               state_in = S_INSRD;
            end
         end
         S_INSRD: begin
            q_raddr = CIW'(head_ff + j_ff[CIW-1:0] - CIW'(1));
            if (j_ff == '0) state_in = S_INSPUT;
            else            state_in = S_INSCMP;
         end
         S_INSCMP: begin
            // shift larger keys back by one; equal keys stay ahead
            if (q_rd_ff.key > key_ff) begin
               q_we     = 1'b1;
               j_in     = j_ff - (CIW+1)'(1);
               state_in = S_INSRD;
            end else begin
               state_in = S_INSPUT;
            end
         end
         S_INSPUT: begin
            q_we         = 1'b1;
            q_wdata.node = n_ff;
            q_wdata.key  = key_ff;
            qlen_in      = qlen_ff + (CIW+1)'(1);
            li_in        = li_ff + LCW'(1);
            state_in     = S_NB;
         end
         S_POP: begin
            if (qlen_ff == '0) begin
               state_in = S_FAIL;
            end else begin
               cur_in   = q_rd_ff.node;
               head_in  = head_ff + CIW'(1);
               qlen_in  = qlen_ff - (CIW+1)'(1);
               state_in = S_EXP;
            end
         end
         S_BLD0: begin
            state_in = S_BLD;
         end
         S_BLD: begin
            if (par_rd_ff != start_ff && int'(cnt_ff) < CELL_COUNT - 1) begin
               stk_we    = 1'b1;
               stk_wdata = par_rd_ff;
               cnt_in    = cnt_ff + CIW'(1);
               par_raddr = par_rd_ff;
            end else begin
               cnt_in   = cnt_ff - CIW'(1);
               state_in = S_EMRD;
            end
         end
         S_EMRD: begin
            state_in = S_EMOUT;
         end
         S_EMOUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = 1'b1;
               rsp_cell_in  = stk_rd_ff;
               rsp_last_in  = (cnt_ff == '0);
               if (cnt_ff == '0) begin
                  state_in = S_IDLE;
               end else begin
                  cnt_in   = cnt_ff - CIW'(1);
                  state_in = S_EMRD;
               end
            end
         end
         S_FAIL: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = 1'b0;
               rsp_cell_in  = '0;
               rsp_last_in  = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         closed_ff    <= '0;
         open_ff      <= '0;
         qlen_ff      <= '0;
         head_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         closed_ff    <= closed_in;
         open_ff      <= open_in;
         qlen_ff      <= qlen_in;
         head_ff      <= head_in;
      end
      cur_ff       <= cur_in;
      start_ff     <= start_in;
      goal_ff      <= goal_in;
      n_ff         <= n_in;
      cnt_ff       <= cnt_in;
      spos_ff      <= spos_in;
      gpos_ff      <= gpos_in;
      li_ff        <= li_in;
      key_ff       <= key_in;
      j_ff         <= j_in;
      rsp_found_ff <= rsp_found_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_cell_ff  <= rsp_cell_in;
   end

   // memory ports: one write and one registered read each
   always_ff @(posedge clock) begin
      if (req_fire && req_operation == OP_LOAD && cell_ok(req_cell_index)) begin
         pos_mem[req_cell_index[CIW-1:0]] <= {take_coord(req_pos_z), take_coord(req_pos_y),
                                              take_coord(req_pos_x)};
         lnk_mem[req_cell_index[CIW-1:0]] <= ld_links;
      end
      pos_rd_ff <= pos_mem[pos_raddr];
      lnk_rd_ff <= lnk_mem[cur_ff];
   end

   always_ff @(posedge clock) begin
      if (par_we) par_mem[par_waddr] <= par_wdata;
      par_rd_ff <= par_mem[par_raddr];
   end

   always_ff @(posedge clock) begin
      if (stk_we) stk_mem[stk_waddr] <= stk_wdata;
      stk_rd_ff <= stk_mem[cnt_ff];
   end

   always_ff @(posedge clock) begin
      if (q_we) q_mem[q_waddr] <= q_wdata;
      q_rd_ff <= q_mem[q_raddr];
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_found      = rsp_found_ff;
   assign rsp_route_cell = 6'(rsp_cell_ff);
   assign rsp_last       = rsp_last_ff;

   a_qlen: assert property (@(posedge clock) disable iff (reset)
      qlen_ff <= (CIW+1)'(CELL_COUNT)) else $error("open queue overflow");
   a_fail_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_found_ff |-> rsp_last_ff) else $error("failure not last");
   a_pop_open: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_POP && qlen_ff != '0 |-> !closed_ff[q_rd_ff.node])
      else $error("closed cell popped from queue");

endmodule

/* design/nbfr_dist.sv */
module nbfr_dist (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    go,
   input  nbfr_pkg::pos_type       pos_a,
   input  nbfr_pkg::pos_type       pos_b,
   output logic                    done,
   output logic [nbfr_pkg::ROOTW-1:0] span
);
   import nbfr_pkg::*;

   typedef enum logic [2:0] {
      D_IDLE = 3'b001,
      D_SQ   = 3'b010,
      D_ROOT = 3'b100
   } dstate_type;

   localparam int RCW = $clog2(ROOTW + 1);

   dstate_type          state_ff, state_in;
   logic [1:0]          k_ff, k_in;
   logic [SUMW-1:0]     sq_ff, sq_in;
   logic [SUMW-1:0]     acc_ff, acc_in;
   logic [SUMW-1:0]     s_ff, s_in;
   logic [ROOTW+2:0]    rem_ff, rem_in;
   logic [ROOTW-1:0]    root_ff, root_in;
   logic [RCW-1:0]      rc_ff, rc_in;
   logic                done_ff, done_in;

   logic [1:0]          ax;
   logic signed [MAGW-1:0] diff;
   logic [MAGW-1:0]     mag;
   logic [2*MAGW-1:0]   sq_prod;
   logic [ROOTW+2:0]    rem_sh, trial;

   assign ax   = (k_ff == 2'd3) ? 2'd0 : k_ff;
   assign diff = signed'({pos_a[ax][COORD_BITS-1], pos_a[ax]})
               - signed'({pos_b[ax][COORD_BITS-1], pos_b[ax]});
   assign mag  = diff[MAGW-1] ? MAGW'(-diff) : MAGW'(diff);
   assign sq_prod = mag * mag;
   assign rem_sh = {rem_ff[ROOTW:0], s_ff[SUMW-1:SUMW-2]};
   assign trial  = {1'b0, root_ff, 2'b01};

   always_comb begin
      state_in = state_ff;
      k_in     = k_ff;
      sq_in    = sq_ff;
      acc_in   = acc_ff;
      s_in     = s_ff;
      rem_in   = rem_ff;
      root_in  = root_ff;
      rc_in    = rc_ff;
      done_in  = 1'b0;
      unique case (state_ff)
         D_IDLE: begin
            if (go) begin
               state_in = D_SQ;
               k_in     = 2'd0;
               acc_in   = '0;
            end
         end
         D_SQ: begin
            sq_in = SUMW'(sq_prod);
            if (k_ff != 2'd0) acc_in = acc_ff + sq_ff;
            k_in = k_ff + 2'd1;
            if (k_ff == 2'd3) begin
               s_in     = acc_ff + sq_ff;
               rem_in   = '0;
               root_in  = '0;
               rc_in    = '0;
               state_in = D_ROOT;
            end
         end
         D_ROOT: begin
            s_in = {s_ff[SUMW-3:0], 2'b00};
            if (rem_sh >= trial) begin
               rem_in  = rem_sh - trial;
               root_in = {root_ff[ROOTW-2:0], 1'b1};
            end else begin
               rem_in  = rem_sh;
               root_in = {root_ff[ROOTW-2:0], 1'b0};
            end
            rc_in = rc_ff + RCW'(1);
            if (rc_ff == RCW'(ROOTW - 1)) begin
               done_in  = 1'b1;
               state_in = D_IDLE;
            end
         end
         default: state_in = D_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= D_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      k_ff    <= k_in;
      sq_ff   <= sq_in;
      acc_ff  <= acc_in;
      s_ff    <= s_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      rc_ff   <= rc_in;
   end

   assign done = done_ff;
   assign span = root_ff;

   a_go_idle: assert property (@(posedge clock) disable iff (reset)
      go |-> state_ff == D_IDLE) else $error("distance start while busy");
   a_done_root: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(state_ff == D_ROOT)) else $error("done without root pass");
   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff) else $error("done longer than one cycle");

endmodule
